@@ design/pblru_pkg.sv @@
// Package for the page buffer tag table: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package pblru_pkg;
    localparam int SLOTS    = 16;
    localparam int AGE_BITS = 32;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_NEW   = 3'd2,
        OP_FLUSH = 3'd3,
        OP_PIN   = 3'd4,
        OP_UNPIN = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_BUF  = 2'd1;
    localparam logic [1:0] ST_NO_VICT  = 2'd2;
    localparam logic [1:0] ST_DISK_ERR = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic scan_start;   // clear search results, begin at slot 0
        logic scan_step;    // examine the slot at the scan index
        logic do_fill;      // fill victim slot with the request tag
        logic do_stamp;     // stamp age of the hit slot
        logic set_dirty;
        logic clr_dirty;
        logic set_pin;
        logic clr_pin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;    // scan index passed the last usable slot
        logic found;        // lookup hit
        logic victim_ok;    // a victim exists
        logic hit_dirty;    // dirty flag of the hit slot
    } t_stat;
endpackage
`default_nettype wire

@@ design/pblru_dp.sv @@
// Datapath of the page buffer tag table: slot tags, flags, ages, access clock,
// and a one-slot-per-cycle scan for lookup and LRU victim. Uses pblru_pkg.
`default_nettype none
module pblru_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire pblru_pkg::t_cmd        i_cmd,
    output pblru_pkg::t_stat            o_stat,
    input  wire logic [4:0]             i_slots_in_use,
    input  wire logic [7:0]             i_file_id,
    input  wire logic [15:0]            i_page_id,
    output logic [3:0]                  o_hit_slot,
    output logic [3:0]                  o_victim_slot,
    output logic                        o_wb_needed,
    output logic [7:0]                  o_victim_file,
    output logic [15:0]                 o_victim_page,
    output logic [7:0]                  o_hit_file,
    output logic [15:0]                 o_hit_page,
    output logic                        o_hit_pinned,
    output logic                        o_hit_dirty
);
    import pblru_pkg::*;

    logic [SLOTS-1:0]    r_valid, r_pinned, r_dirty;
    logic [7:0]          r_file [SLOTS];
    logic [15:0]         r_page [SLOTS];
    logic [AGE_BITS-1:0] r_age  [SLOTS];
    logic [AGE_BITS-1:0] r_clock;

    // scan state
    logic [CNT_W-1:0]    r_idx;
    logic                r_found, r_vacant, r_have;
    logic [SLOT_W-1:0]   r_hit, r_vict;
    logic [AGE_BITS-1:0] r_best_age;

    logic [CNT_W-1:0]    usable;
    logic [SLOT_W-1:0]   cur;
    logic                tag_eq;

    always_comb begin
        usable = (i_slots_in_use == '0) ? CNT_W'(1) :
                 (i_slots_in_use > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : i_slots_in_use;
        cur    = r_idx[SLOT_W-1:0];
        tag_eq = r_valid[cur] && r_file[cur] == i_file_id && r_page[cur] == i_page_id;
    end

    // scan one slot a cycle: first hit, lowest vacant, else oldest unpinned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0; r_found <= 1'b0; r_vacant <= 1'b0; r_have <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_idx <= '0; r_found <= 1'b0; r_vacant <= 1'b0; r_have <= 1'b0;
        end else if (i_cmd.scan_step && r_idx < usable) begin
            r_idx <= r_idx + CNT_W'(1);
            if (tag_eq && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= cur;
            end
            if (!r_valid[cur]) begin
                if (!r_vacant) begin
                    r_vacant <= 1'b1;
                    r_have   <= 1'b1;
                    r_vict   <= cur;
                end
            end else if (!r_vacant && !r_pinned[cur] &&
                         (!r_have || r_age[cur] < r_best_age)) begin
                r_have     <= 1'b1;
                r_vict     <= cur;
                r_best_age <= r_age[cur];
            end
        end
    end

    // slot updates and access clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_pinned <= '0; r_dirty <= '0; r_clock <= '0;
        end else begin
            if (i_cmd.do_fill) begin
                r_valid[r_vict]  <= 1'b1;
                r_pinned[r_vict] <= 1'b0;
                r_dirty[r_vict]  <= 1'b0;
                r_file[r_vict]   <= i_file_id;
                r_page[r_vict]   <= i_page_id;
                r_age[r_vict]    <= r_clock;
            end
            if (i_cmd.do_stamp) r_age[r_hit] <= r_clock;
            if (i_cmd.do_fill || i_cmd.do_stamp) begin
                if (r_clock != '1) r_clock <= r_clock + AGE_BITS'(1);
            end
            if (i_cmd.set_dirty) r_dirty[r_hit]  <= 1'b1;
            if (i_cmd.clr_dirty) r_dirty[r_hit]  <= 1'b0;
            if (i_cmd.set_pin)   r_pinned[r_hit] <= 1'b1;
            if (i_cmd.clr_pin)   r_pinned[r_hit] <= 1'b0;
        end
    end

    always_comb begin
        o_stat.scan_done = (r_idx >= usable);
        o_stat.found     = r_found;
        o_stat.victim_ok = r_have;
        o_stat.hit_dirty = r_dirty[r_hit];
        o_hit_slot       = r_hit;
        o_victim_slot    = r_vict;
        o_wb_needed      = r_valid[r_vict] && r_dirty[r_vict];
        o_victim_file    = r_file[r_vict];
        o_victim_page    = r_page[r_vict];
        o_hit_file       = r_file[r_hit];
        o_hit_page       = r_page[r_hit];
        o_hit_pinned     = r_pinned[r_hit];
        o_hit_dirty      = r_dirty[r_hit];
    end
endmodule
`default_nettype wire

@@ design/pblru_ctrl.sv @@
// Controller of the page buffer tag table: sequences scan, decision, update
// and result register. Uses pblru_pkg and drives pblru_dp by command struct.
`default_nettype none
module pblru_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [2:0]      i_op,
    input  wire logic            i_disk_ok,
    output logic                 o_cap,
    output pblru_pkg::t_cmd      o_cmd,
    input  wire pblru_pkg::t_stat i_stat,
    input  wire logic [3:0]      i_hit_slot,
    input  wire logic [3:0]      i_victim_slot,
    input  wire logic            i_wb_needed,
    input  wire logic [7:0]      i_victim_file,
    input  wire logic [15:0]     i_victim_page,
    input  wire logic [7:0]      i_hit_file,
    input  wire logic [15:0]     i_hit_page,
    input  wire logic            i_hit_pinned,
    input  wire logic            i_hit_dirty,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [1:0]           o_status,
    output logic [3:0]           o_slot,
    output logic                 o_hit,
    output logic                 o_fetch_request,
    output logic                 o_writeback_request,
    output logic [7:0]           o_writeback_file,
    output logic [15:0]          o_writeback_page,
    output logic                 o_pinned,
    output logic                 o_dirty
);
    import pblru_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_REPORT = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    // kind of report: no slot, hit slot, filled slot
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_HIT  = 2'd1;
    localparam logic [1:0] K_FILL = 2'd2;

    t_state     r_state, n_state;
    logic [2:0] r_op;
    logic       r_ok;
    logic [1:0] r_kind, n_kind;
    logic [1:0] r_st, n_st;
    logic       r_fetch, n_fetch, r_wb, n_wb;
    logic [7:0] r_wbf, n_wbf;
    logic [15:0] r_wbp, n_wbp;
    logic       r_hitf, n_hitf;

    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_cap   = (r_state == S_IDLE) && i_valid;
        o_valid = (r_state == S_OUT);
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_kind = r_kind; n_st = r_st; n_fetch = r_fetch; n_wb = r_wb;
        n_wbf = r_wbf; n_wbp = r_wbp; n_hitf = r_hitf;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_kind = K_NONE; n_st = ST_OK; n_fetch = 1'b0; n_wb = 1'b0;
                n_wbf = '0; n_wbp = '0; n_hitf = 1'b0;
                n_state = S_REPORT;
                if (r_op == OP_READ && i_stat.found) begin
                    n_kind = K_HIT; n_hitf = 1'b1; o_cmd.do_stamp = 1'b1;
                end else if (r_op == OP_READ || r_op == OP_NEW) begin
                    if (r_op == OP_NEW && !r_ok)      n_st = ST_DISK_ERR;
                    else if (!i_stat.victim_ok)       n_st = ST_NO_VICT;
                    else if (!r_ok)                   n_st = ST_DISK_ERR;
                    else begin
                        n_kind = K_FILL; o_cmd.do_fill = 1'b1;
                        n_fetch = (r_op == OP_READ);
                        n_wb = i_wb_needed;
                        if (i_wb_needed) begin
                            n_wbf = i_victim_file; n_wbp = i_victim_page;
                        end
                    end
                end else if (r_op == OP_WRITE || r_op == OP_FLUSH ||
                             r_op == OP_PIN || r_op == OP_UNPIN) begin
                    if (!i_stat.found) n_st = ST_NOT_BUF;
                    else begin
                        n_kind = K_HIT; n_hitf = 1'b1;
                        if (r_op == OP_WRITE) begin
                            o_cmd.set_dirty = 1'b1; o_cmd.do_stamp = 1'b1;
                        end else if (r_op == OP_PIN)   o_cmd.set_pin = 1'b1;
                        else if (r_op == OP_UNPIN)     o_cmd.clr_pin = 1'b1;
                        else if (i_stat.hit_dirty) begin
                            if (!r_ok) n_st = ST_DISK_ERR;
                            else begin
                                o_cmd.clr_dirty = 1'b1; n_wb = 1'b1;
                                n_wbf = i_hit_file; n_wbp = i_hit_page;
                            end
                        end
                    end
                end else begin
                    n_st = ST_NOT_BUF;
                end
            end
            S_REPORT: n_state = S_OUT;
            S_OUT:    if (!i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold request, decision, and result payload
    always_ff @(posedge i_clk) begin
        if (o_cap) begin
            r_op <= i_op; r_ok <= i_disk_ok;
        end
        r_kind <= n_kind; r_st <= n_st; r_fetch <= n_fetch; r_wb <= n_wb;
        r_wbf <= n_wbf; r_wbp <= n_wbp; r_hitf <= n_hitf;
        if (r_state == S_REPORT) begin
            o_status            <= r_st;
            o_hit               <= r_hitf;
            o_fetch_request     <= r_fetch;
            o_writeback_request <= r_wb;
            o_writeback_file    <= r_wbf;
            o_writeback_page    <= r_wbp;
            o_slot   <= (r_kind == K_HIT) ? i_hit_slot :
                        (r_kind == K_FILL) ? i_victim_slot : 4'd0;
            o_pinned <= (r_kind == K_HIT) ? i_hit_pinned : 1'b0;
            o_dirty  <= (r_kind == K_HIT) ? i_hit_dirty : 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ design/page_buffer_lru_pin_dirty_top.sv @@
// Top level of the page buffer tag table (LRU, pin, dirty).
// Instantiates pblru_ctrl and pblru_dp; uses pblru_pkg.
//
// Usage:
//  - Request channel: i_valid/o_stall with i_op, i_file_id, i_page_id,
//    i_disk_ok. A transfer happens when i_valid is high and o_stall low.
//  - Result channel: o_valid/i_stall with status, slot, hit, fetch and
//    writeback fields; a transfer happens when o_valid is high and i_stall low.
//  - Configuration: i_cfg_valid/o_cfg_ready with i_cfg_data (slots_in_use).
//    Write only while the block is idle.
//  - One request at a time. After a request transfers, the datapath scans
//    the usable slots (up to 16) one slot per cycle for both the lookup
//    and the LRU victim; the controller then sees the end of the scan,
//    decides and updates the slot, and registers the result, which is
//    presented on the result channel. A new request is taken only once
//    that result has transferred.
//  - Reset (synchronous, active low) empties all slots, zeroes the access
//    clock and sets slots_in_use to 16. No clearing pass is needed.
//  - A stalled result holds steady; no new request is taken until it leaves.
`default_nettype none
module page_buffer_lru_pin_dirty_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [7:0]  i_file_id,
    input  wire logic [15:0] i_page_id,
    input  wire logic        i_disk_ok,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_slot,
    output logic             o_hit,
    output logic             o_fetch_request,
    output logic             o_writeback_request,
    output logic [7:0]       o_writeback_file,
    output logic [15:0]      o_writeback_page,
    output logic             o_pinned,
    output logic             o_dirty,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data
);
    import pblru_pkg::*;

    logic [4:0]  r_slots_in_use;
    logic [7:0]  r_file;
    logic [15:0] r_page;
    logic        cap;
    t_cmd        cmd;
    t_stat       stat;
    logic [3:0]  hit_slot, vict_slot;
    logic        wb_needed, hit_pinned, hit_dirty;
    logic [7:0]  vict_file, hit_file;
    logic [15:0] vict_page, hit_page;

    assign o_cfg_ready = 1'b1;

    // hold configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= 5'd16;
        end else if (i_cfg_valid) begin
            r_slots_in_use <= i_cfg_data;
        end
    end

    // hold request tag for the scan
    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_file <= i_file_id; r_page <= i_page_id;
        end
    end

    pblru_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_disk_ok,
        .o_cap(cap), .o_cmd(cmd), .i_stat(stat),
        .i_hit_slot(hit_slot), .i_victim_slot(vict_slot), .i_wb_needed(wb_needed),
        .i_victim_file(vict_file), .i_victim_page(vict_page),
        .i_hit_file(hit_file), .i_hit_page(hit_page),
        .i_hit_pinned(hit_pinned), .i_hit_dirty(hit_dirty),
        .o_valid, .i_stall, .o_status, .o_slot, .o_hit, .o_fetch_request,
        .o_writeback_request, .o_writeback_file, .o_writeback_page,
        .o_pinned, .o_dirty
    );

    pblru_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_slots_in_use(r_slots_in_use), .i_file_id(r_file), .i_page_id(r_page),
        .o_hit_slot(hit_slot), .o_victim_slot(vict_slot), .o_wb_needed(wb_needed),
        .o_victim_file(vict_file), .o_victim_page(vict_page),
        .o_hit_file(hit_file), .o_hit_page(hit_page),
        .o_hit_pinned(hit_pinned), .o_hit_dirty(hit_dirty)
    );

    a_fill_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.do_fill && cmd.do_stamp)) else $error("fill and stamp together");
    a_fetch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fetch_request |-> o_status == ST_OK && !o_hit)
        else $error("fetch with bad status");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("request taken while result pending");
endmodule
`default_nettype wire

@@ test/page_buffer_lru_pin_dirty_top_tb.sv @@
// Testbench for page_buffer_lru_pin_dirty_top: predicts each result of the
// LRU page buffer tag table and checks it field by field. Uses pblru_pkg.
`timescale 1ns / 1ps
module page_buffer_lru_pin_dirty_top_tb;
    import pblru_pkg::*;

    localparam logic [2:0] OP_BAD_6 = 3'd6;
    localparam logic [2:0] OP_BAD_7 = 3'd7;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic        hit;
        logic        fetch;
        logic        wb;
        logic [7:0]  wb_file;
        logic [15:0] wb_page;
        logic        pinned;
        logic        dirty;
    } t_page_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_op;
    logic [7:0]  i_file_id;
    logic [15:0] i_page_id;
    logic        i_disk_ok;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [3:0]  o_slot;
    logic        o_hit;
    logic        o_fetch_request;
    logic        o_writeback_request;
    logic [7:0]  o_writeback_file;
    logic [15:0] o_writeback_page;
    logic        o_pinned;
    logic        o_dirty;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    page_buffer_lru_pin_dirty_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_file_id(i_file_id), .i_page_id(i_page_id),
        .i_disk_ok(i_disk_ok),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_slot(o_slot), .o_hit(o_hit),
        .o_fetch_request(o_fetch_request),
        .o_writeback_request(o_writeback_request),
        .o_writeback_file(o_writeback_file), .o_writeback_page(o_writeback_page),
        .o_pinned(o_pinned), .o_dirty(o_dirty),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow tag table
    logic                tag_valid  [SLOTS];
    logic [7:0]          tag_file   [SLOTS];
    logic [15:0]         tag_page   [SLOTS];
    logic                tag_pinned [SLOTS];
    logic                tag_dirty  [SLOTS];
    logic [AGE_BITS-1:0] tag_age    [SLOTS];
    logic [AGE_BITS-1:0] lru_clock;
    logic [4:0]          slots_reg;

    t_page_result pending_results[$];
    int  errors = 0;
    int  hold_off_cycles = 0;
    int  burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("page_buffer_lru_pin_dirty_top_tb failed");
        $finish;
    end

    function automatic int usable_slots();
        if (slots_reg < 1) return 1;
        if (slots_reg > SLOTS) return SLOTS;
        return slots_reg;
    endfunction

    function automatic int find_page(logic [7:0] f, logic [15:0] p);
        for (int i = 0; i < usable_slots(); i++)
            if (tag_valid[i] && tag_file[i] == f && tag_page[i] == p) return i;
        return -1;
    endfunction

    // vacant slot first, then oldest unpinned, lowest index on ties
    function automatic int choose_victim();
        int best;
        best = -1;
        for (int i = 0; i < usable_slots(); i++)
            if (!tag_valid[i]) return i;
        for (int i = 0; i < usable_slots(); i++)
            if (!tag_pinned[i] && (best < 0 || tag_age[i] < tag_age[best])) best = i;
        return best;
    endfunction

    function automatic void touch_age(int s);
        tag_age[s] = lru_clock;
        if (lru_clock != '1) lru_clock = lru_clock + 1;
    endfunction

    function automatic void load_slot(int s, logic [7:0] f, logic [15:0] p,
                                      ref t_page_result r);
        if (tag_valid[s] && tag_dirty[s]) begin
            r.wb = 1'b1;
            r.wb_file = tag_file[s];
            r.wb_page = tag_page[s];
        end
        tag_valid[s] = 1'b1;
        tag_file[s] = f;
        tag_page[s] = p;
        tag_pinned[s] = 1'b0;
        tag_dirty[s] = 1'b0;
        touch_age(s);
    endfunction

    function automatic t_page_result predict_page_access(logic [2:0] op, logic [7:0] f,
                                                         logic [15:0] p, logic ok);
        t_page_result r;
        int s;
        r = '0;
        s = -1;
        case (op)
            OP_READ: begin
                s = find_page(f, p);
                if (s >= 0) begin
                    r.hit = 1'b1;
                    touch_age(s);
                end else begin
                    s = choose_victim();
                    if (s < 0) r.status = ST_NO_VICT;
                    else if (!ok) begin
                        r.status = ST_DISK_ERR;
                        s = -1;
                    end else begin
                        load_slot(s, f, p, r);
                        r.fetch = 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                s = find_page(f, p);
                if (s < 0) r.status = ST_NOT_BUF;
                else begin
                    r.hit = 1'b1;
                    tag_dirty[s] = 1'b1;
                    touch_age(s);
                end
            end
            OP_NEW: begin
                if (!ok) r.status = ST_DISK_ERR;
                else begin
                    s = choose_victim();
                    if (s < 0) r.status = ST_NO_VICT;
                    else load_slot(s, f, p, r);
                end
            end
            OP_FLUSH: begin
                s = find_page(f, p);
                if (s < 0) r.status = ST_NOT_BUF;
                else begin
                    r.hit = 1'b1;
                    if (tag_dirty[s]) begin
                        if (!ok) r.status = ST_DISK_ERR;
                        else begin
                            r.wb = 1'b1;
                            r.wb_file = tag_file[s];
                            r.wb_page = tag_page[s];
                            tag_dirty[s] = 1'b0;
                        end
                    end
                end
            end
            OP_PIN, OP_UNPIN: begin
                s = find_page(f, p);
                if (s < 0) r.status = ST_NOT_BUF;
                else begin
                    r.hit = 1'b1;
                    tag_pinned[s] = (op == OP_PIN);
                end
            end
            default: r.status = ST_NOT_BUF;
        endcase
        if (s >= 0) begin
            r.slot = s[3:0];
            r.pinned = tag_pinned[s];
            r.dirty = tag_dirty[s];
        end
        return r;
    endfunction

    // offer one request and hold it until transferred
    task automatic send_request(logic [2:0] op, logic [7:0] f, logic [15:0] p, logic ok);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_op <= op;
        i_file_id <= f;
        i_page_id <= p;
        i_disk_ok <= ok;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_page_access(op, f, p, ok));
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // send in bursts with random gaps between them
    task automatic send_paced(logic [2:0] op, logic [7:0] f, logic [15:0] p, logic ok);
        send_request(op, f, p, ok);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slots_in_use(logic [4:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        slots_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_paced(OP_WRITE, 8'd1, 16'd1, 1'b1);
        send_paced(OP_FLUSH, 8'd1, 16'd1, 1'b1);
        send_paced(OP_PIN, 8'd1, 16'd1, 1'b1);
        send_paced(OP_UNPIN, 8'd1, 16'd1, 1'b1);
        send_paced(OP_BAD_6, 8'd1, 16'd1, 1'b1);
        send_paced(OP_BAD_7, 8'hFF, 16'hFFFF, 1'b0);
        send_paced(OP_READ, 8'hFF, 16'hFFFF, 1'b0);
        send_paced(OP_READ, 8'hFF, 16'hFFFF, 1'b1);
        send_paced(OP_READ, 8'h00, 16'h0000, 1'b1);
        send_paced(OP_READ, 8'hFF, 16'hFFFF, 1'b0);
        send_paced(OP_WRITE, 8'hFF, 16'hFFFF, 1'b1);
        send_paced(OP_FLUSH, 8'hFF, 16'hFFFF, 1'b0);
        send_paced(OP_FLUSH, 8'hFF, 16'hFFFF, 1'b1);
        send_paced(OP_FLUSH, 8'hFF, 16'hFFFF, 1'b1);
        send_paced(OP_PIN, 8'h00, 16'h0000, 1'b0);
        send_paced(OP_UNPIN, 8'h00, 16'h0000, 1'b1);
        send_paced(OP_NEW, 8'h55, 16'hAAAA, 1'b0);
        send_paced(OP_NEW, 8'hFF, 16'hFFFF, 1'b1);
        send_paced(OP_NEW, 8'hAA, 16'h5555, 1'b1);
    endtask

    // two usable slots: pin both to run out of victims, then evict a dirty page
    task automatic test_victims();
        write_slots_in_use(5'd2);
        send_paced(OP_READ, 8'd7, 16'd1, 1'b1);
        send_paced(OP_READ, 8'd7, 16'd2, 1'b1);
        send_paced(OP_PIN, 8'd7, 16'd1, 1'b1);
        send_paced(OP_PIN, 8'd7, 16'd2, 1'b1);
        send_paced(OP_READ, 8'd7, 16'd3, 1'b1);
        send_paced(OP_NEW, 8'd7, 16'd3, 1'b1);
        send_paced(OP_WRITE, 8'd7, 16'd2, 1'b1);
        send_paced(OP_UNPIN, 8'd7, 16'd2, 1'b1);
        send_paced(OP_READ, 8'd7, 16'd3, 1'b1);
        send_paced(OP_NEW, 8'd7, 16'd4, 1'b1);
    endtask

    // mostly a small working set so hits, evictions and pins interact
    task automatic random_request();
        logic [2:0]  op;
        logic [7:0]  f;
        logic [15:0] p;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) op = OP_READ;
        else if (pick < 48) op = OP_WRITE;
        else if (pick < 56) op = OP_NEW;
        else if (pick < 68) op = OP_FLUSH;
        else if (pick < 78) op = OP_PIN;
        else if (pick < 94) op = OP_UNPIN;
        else op = 3'($urandom_range(OP_BAD_6, OP_BAD_7));
        if ($urandom_range(0, 19) == 0) begin
            f = 8'($urandom);
            p = 16'($urandom);
        end else begin
            f = 8'($urandom_range(0, 3)) ^ {8{($urandom_range(0, 9) == 0)}};
            p = 16'($urandom_range(0, 9)) ^ {16{($urandom_range(0, 9) == 0)}};
        end
        send_paced(op, f, p, $urandom_range(0, 99) < 88);
    endtask

    task automatic test_random(logic [4:0] slots_value, int n);
        write_slots_in_use(slots_value);
        repeat (n) random_request();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_off_cycles = 400;
        repeat (25) random_request();
    endtask

    task automatic test_pause_until_drained();
        repeat (20) random_request();
        wait_drained();
        repeat (20) random_request();
    endtask

    // receiver stall pattern, overridden by a long hold-off when asked
    initial begin
        int mode_cycles;
        int mode;
        mode_cycles = 0;
        mode = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_stall <= 1'b1;
            end else begin
                if (mode_cycles == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_cycles = $urandom_range(20, 150);
                end
                mode_cycles--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 9) < 3);
                    2: i_stall <= mode_cycles[0];
                    default: i_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_page_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_slot !== e.slot) begin
                    $error("slot: expected %0d actual %0d", e.slot, o_slot);
                    errors++;
                end
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d actual %0d", e.hit, o_hit);
                    errors++;
                end
                if (o_fetch_request !== e.fetch) begin
                    $error("fetch_request: expected %0d actual %0d", e.fetch,
                           o_fetch_request);
                    errors++;
                end
                if (o_writeback_request !== e.wb) begin
                    $error("writeback_request: expected %0d actual %0d", e.wb,
                           o_writeback_request);
                    errors++;
                end
                if (o_writeback_file !== e.wb_file) begin
                    $error("writeback_file: expected %0h actual %0h", e.wb_file,
                           o_writeback_file);
                    errors++;
                end
                if (o_writeback_page !== e.wb_page) begin
                    $error("writeback_page: expected %0h actual %0h", e.wb_page,
                           o_writeback_page);
                    errors++;
                end
                if (o_pinned !== e.pinned) begin
                    $error("pinned: expected %0d actual %0d", e.pinned, o_pinned);
                    errors++;
                end
                if (o_dirty !== e.dirty) begin
                    $error("dirty: expected %0d actual %0d", e.dirty, o_dirty);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_READ;
        i_file_id = '0;
        i_page_id = '0;
        i_disk_ok = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tag_valid[i] = 1'b0;
            tag_file[i] = '0;
            tag_page[i] = '0;
            tag_pinned[i] = 1'b0;
            tag_dirty[i] = 1'b0;
            tag_age[i] = '0;
        end
        lru_clock = '0;
        slots_reg = 5'd16;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_victims();
        test_random(5'd16, 400);
        test_backpressure();
        test_random(5'd1, 100);
        test_random(5'd0, 60);
        test_random(5'd31, 200);
        test_pause_until_drained();
        test_random(5'd5, 200);
        test_random(5'd8, 200);
        test_random(5'($urandom_range(2, 15)), 100);
        test_random(5'd16, 60);

        wait_drained();
        if (errors == 0) $display("page_buffer_lru_pin_dirty_top_tb passed");
        else $display("page_buffer_lru_pin_dirty_top_tb failed");
        $finish;
    end
endmodule

@@ filelist.f @@
design/pblru_pkg.sv
design/pblru_dp.sv
design/pblru_ctrl.sv
design/page_buffer_lru_pin_dirty_top.sv
test/page_buffer_lru_pin_dirty_top_tb.sv
